// ===== hw/rtl/ffsa_pkg.sv =====
// Shared types and constants for the first-fit segment allocator.
package ffsa_pkg;

    localparam int MAX_SEGMENTS = 1024;
    localparam int BLOCK_WIDTH  = 16;
    localparam int IDX_W        = $clog2(MAX_SEGMENTS);
    localparam int CNT_W        = IDX_W + 1;
    localparam int NEED_W       = BLOCK_WIDTH + 1;

    localparam logic [1:0] ACT_LOAD    = 2'd0;
    localparam logic [1:0] ACT_ALLOC   = 2'd1;
    localparam logic [1:0] ACT_RELEASE = 2'd2;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_NOFIT = 2'd1;
    localparam logic [1:0] ERR_FULL  = 2'd2;

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SEGMENTS);

    typedef struct packed {
        logic                   used;
        logic [BLOCK_WIDTH-1:0] first;
        logic [BLOCK_WIDTH-1:0] last;
    } t_seg;

    // Queue command from the sequencer to the cell chain.
    typedef struct packed {
        logic pop;
        logic push;
        t_seg seg;
    } t_chain_cmd;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SCAN  = 7'b0000010,
        S_SPLIT = 7'b0000100,
        S_MERGE = 7'b0001000,
        S_FLUSH = 7'b0010000,
        S_DONE  = 7'b0100000,
        S_SPARE = 7'b1000000
    } t_state;

endpackage

// ===== hw/rtl/ffsa_cell.sv =====
// One cell of the segment chain: holds one table entry.
module ffsa_cell (
    input  logic          i_clk,
    input  logic          i_shift,
    input  logic          i_write,
    input  ffsa_pkg::t_seg i_push_seg,
    input  ffsa_pkg::t_seg i_next_seg,
    output ffsa_pkg::t_seg o_seg
);
    import ffsa_pkg::*;

    t_seg r_seg;
    t_seg n_seg;

    // Take the new entry, the neighbour's entry, or hold
    always_comb begin
        if (i_write) begin
            n_seg = i_push_seg;
        end else if (i_shift) begin
            n_seg = i_next_seg;
        end else begin
            n_seg = r_seg;
        end
    end

    always_ff @(posedge i_clk) begin
        r_seg <= n_seg;
    end

    assign o_seg = r_seg;

endmodule

// ===== hw/rtl/ffsa_chain.sv =====
// Chain of cells forming the address-ordered segment queue.
module ffsa_chain (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  ffsa_pkg::t_chain_cmd     i_cmd,
    output ffsa_pkg::t_seg           o_head,
    output logic [ffsa_pkg::CNT_W-1:0] o_count
);
    import ffsa_pkg::*;

    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic [CNT_W-1:0] w_wptr;
    t_seg             w_cell [MAX_SEGMENTS];

    // Append slot sits one lower when the head leaves in the same cycle
    assign w_wptr = i_cmd.pop ? (r_cnt - CNT_W'(1)) : r_cnt;

    always_comb begin
        n_cnt = r_cnt;
        if (i_cmd.push && !i_cmd.pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (!i_cmd.push && i_cmd.pop) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // Build the row; each cell passes its entry towards the head on a pop
    for (genvar k = 0; k < MAX_SEGMENTS; k++) begin : g_cell
        t_seg w_next;
        if (k == MAX_SEGMENTS - 1) begin : g_last
            assign w_next = '0;
        end else begin : g_mid
            assign w_next = w_cell[k+1];
        end
        ffsa_cell u_cell (
            .i_clk      (i_clk),
            .i_shift    (i_cmd.pop),
            .i_write    (i_cmd.push && (w_wptr == CNT_W'(k))),
            .i_push_seg (i_cmd.seg),
            .i_next_seg (w_next),
            .o_seg      (w_cell[k])
        );
    end

    assign o_head  = w_cell[0];
    assign o_count = r_cnt;

endmodule

// ===== hw/rtl/ffsa_ctrl.sv =====
// Sequencer: scan pass with split, merge pass, and the result register.
module ffsa_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [1:0]                     i_action,
    input  logic                           i_load_used,
    input  logic [ffsa_pkg::BLOCK_WIDTH-1:0] i_load_first,
    input  logic [ffsa_pkg::BLOCK_WIDTH-1:0] i_load_last,
    input  logic [ffsa_pkg::NEED_W-1:0]    i_block_count,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_ok,
    output logic [1:0]                     o_error_code,
    output logic [ffsa_pkg::BLOCK_WIDTH-1:0] o_granted_first,
    output logic [ffsa_pkg::BLOCK_WIDTH-1:0] o_granted_last,
    output logic [ffsa_pkg::NEED_W-1:0]    o_released_total,
    output logic [ffsa_pkg::CNT_W-1:0]     o_segments_now,
    output ffsa_pkg::t_chain_cmd           o_cmd,
    input  ffsa_pkg::t_seg                 i_head,
    input  logic [ffsa_pkg::CNT_W-1:0]     i_count
);
    import ffsa_pkg::*;

    t_state             r_state, n_state;
    logic [1:0]         r_act;
    logic [NEED_W-1:0]  r_need;
    logic [NEED_W-1:0]  r_left, n_left;
    logic               r_done, n_done;
    logic               r_full_hit, n_full_hit;
    logic               r_ok, n_ok;
    logic [1:0]         r_err, n_err;
    logic [BLOCK_WIDTH-1:0] r_gf, n_gf, r_gl, n_gl;
    logic [CNT_W-1:0]   r_pops, n_pops;
    t_seg               r_tail, n_tail;
    t_seg               r_hold, n_hold;
    logic               r_hold_v, n_hold_v;
    logic               r_ovalid, n_ovalid;
    logic               r_ook;
    logic [1:0]         r_oerr;
    logic [BLOCK_WIDTH-1:0] r_ogf, r_ogl;
    logic [NEED_W-1:0]  r_orel;
    logic [CNT_W-1:0]   r_ocnt;

    logic               w_in_acc;
    logic               w_out_load;
    logic [NEED_W-1:0]  w_size;
    logic [NEED_W-1:0]  w_amt;
    logic [NEED_W-1:0]  w_sum;
    logic               w_full;
    logic               w_ok_end;
    logic               w_mergeable;
    logic [NEED_W-1:0]  w_released;
    t_chain_cmd         w_cmd;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_out_load = (r_state == S_DONE) && (!r_ovalid || i_out_ready);
    assign w_full     = (i_count == CNT_MAX);

    // Head entry size, zero for a reversed segment
    assign w_size = (i_head.last < i_head.first) ? '0 :
        (NEED_W'(i_head.last) - NEED_W'(i_head.first) + NEED_W'(1));
    assign w_amt  = (r_act == ACT_ALLOC) ? r_need : r_left;
    assign w_sum  = NEED_W'(i_head.first) + w_amt;

    assign w_ok_end = (r_act == ACT_ALLOC) ? r_ok :
                      ((r_act == ACT_RELEASE) && (r_left != r_need));
    assign w_mergeable = (r_hold.used == i_head.used) &&
        ((NEED_W'(r_hold.last) + NEED_W'(1)) == NEED_W'(i_head.first));
    assign w_released = (r_act == ACT_RELEASE) ? (r_need - r_left) : '0;

    always_comb begin
        n_state    = r_state;
        n_left     = r_left;
        n_done     = r_done;
        n_full_hit = r_full_hit;
        n_ok       = r_ok;
        n_err      = r_err;
        n_gf       = r_gf;
        n_gl       = r_gl;
        n_pops     = r_pops;
        n_tail     = r_tail;
        n_hold     = r_hold;
        n_hold_v   = r_hold_v;
        w_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_left     = i_block_count;
                    n_done     = 1'b0;
                    n_full_hit = 1'b0;
                    n_ok       = 1'b0;
                    n_err      = ERR_NOFIT;
                    n_gf       = '0;
                    n_gl       = '0;
                    n_pops     = i_count;
                    if (i_action == ACT_LOAD) begin
                        // Append straight to the tail
                        if (w_full) begin
                            n_err = ERR_FULL;
                        end else begin
                            w_cmd.push       = 1'b1;
                            w_cmd.seg.used   = i_load_used;
                            w_cmd.seg.first  = i_load_first;
                            w_cmd.seg.last   = i_load_last;
                            n_ok             = 1'b1;
                            n_err            = ERR_NONE;
                        end
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_pops != '0) begin
                    // Pop one entry, rewrite it, append it at the tail
                    w_cmd.pop  = 1'b1;
                    w_cmd.push = 1'b1;
                    w_cmd.seg  = i_head;
                    n_pops     = r_pops - CNT_W'(1);
                    if ((r_act == ACT_ALLOC) && (r_need != '0) && !r_done &&
                        !i_head.used) begin
                        if (w_size == r_need) begin
                            w_cmd.seg.used = 1'b1;
                            n_ok   = 1'b1;
                            n_gf   = i_head.first;
                            n_gl   = i_head.last;
                            n_done = 1'b1;
                        end else if (w_size > r_need) begin
                            n_done = 1'b1;
                            if (w_full) begin
                                n_full_hit = 1'b1;
                            end else begin
                                w_cmd.seg.used  = 1'b1;
                                w_cmd.seg.last  = BLOCK_WIDTH'(w_sum - NEED_W'(1));
                                n_tail.used     = 1'b0;
                                n_tail.first    = BLOCK_WIDTH'(w_sum);
                                n_tail.last     = i_head.last;
                                n_ok            = 1'b1;
                                n_gf            = i_head.first;
                                n_gl            = BLOCK_WIDTH'(w_sum - NEED_W'(1));
                                n_state         = S_SPLIT;
                            end
                        end
                    end else if ((r_act == ACT_RELEASE) && (r_left != '0) && !r_done &&
                                 i_head.used) begin
                        if (w_size <= r_left) begin
                            w_cmd.seg.used = 1'b0;
                            n_left = r_left - w_size;
                        end else begin
                            n_done = 1'b1;
                            if (w_full) begin
                                n_full_hit = 1'b1;
                            end else begin
                                w_cmd.seg.used  = 1'b0;
                                w_cmd.seg.last  = BLOCK_WIDTH'(w_sum - NEED_W'(1));
                                n_tail.used     = 1'b1;
                                n_tail.first    = BLOCK_WIDTH'(w_sum);
                                n_tail.last     = i_head.last;
                                n_left          = '0;
                                n_state         = S_SPLIT;
                            end
                        end
                    end
                end else begin
                    // End of scan: settle status, merge only on success
                    n_ok = w_ok_end;
                    if (r_full_hit) begin
                        n_err = ERR_FULL;
                    end else if (w_ok_end) begin
                        n_err = ERR_NONE;
                    end else begin
                        n_err = ERR_NOFIT;
                    end
                    n_pops   = i_count;
                    n_hold_v = 1'b0;
                    n_state  = w_ok_end ? S_MERGE : S_DONE;
                end
            end
            S_SPLIT: begin
                // Append the split tail without popping
                w_cmd.push = 1'b1;
                w_cmd.seg  = r_tail;
                n_state    = S_SCAN;
            end
            S_MERGE: begin
                if (r_pops != '0) begin
                    w_cmd.pop = 1'b1;
                    n_pops    = r_pops - CNT_W'(1);
                    if (!r_hold_v) begin
                        n_hold   = i_head;
                        n_hold_v = 1'b1;
                    end else if (w_mergeable) begin
                        n_hold.last = i_head.last;
                    end else begin
                        w_cmd.push = 1'b1;
                        w_cmd.seg  = r_hold;
                        n_hold     = i_head;
                    end
                end else begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                // Drop the held entry back into the chain
                w_cmd.push = r_hold_v;
                w_cmd.seg  = r_hold;
                n_hold_v   = 1'b0;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output slot fills from DONE, drains on an accepted beat
    always_comb begin
        n_ovalid = r_ovalid;
        if (w_out_load) begin
            n_ovalid = 1'b1;
        end else if (i_out_ready) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_hold_v <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_hold_v <= n_hold_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_act  <= i_action;
            r_need <= i_block_count;
        end
        r_left     <= n_left;
        r_done     <= n_done;
        r_full_hit <= n_full_hit;
        r_ok       <= n_ok;
        r_err      <= n_err;
        r_gf       <= n_gf;
        r_gl       <= n_gl;
        r_pops     <= n_pops;
        r_tail     <= n_tail;
        r_hold     <= n_hold;
        if (w_out_load) begin
            r_ook  <= r_ok;
            r_oerr <= r_err;
            r_ogf  <= r_gf;
            r_ogl  <= r_gl;
            r_orel <= w_released;
            r_ocnt <= i_count;
        end
    end

    assign o_cmd            = w_cmd;
    assign o_out_valid      = r_ovalid;
    assign o_ok             = r_ook;
    assign o_error_code     = r_oerr;
    assign o_granted_first  = r_ogf;
    assign o_granted_last   = r_ogl;
    assign o_released_total = r_orel;
    assign o_segments_now   = r_ocnt;

endmodule

// ===== hw/rtl/first_fit_segment_allocator.sv =====
// Top level of the first-fit segment allocator: sequencer and cell chain.
//
//   beat     | handshake                  | payload
//   ---------+----------------------------+------------------------------------------
//   request  | i_in_valid / o_in_ready    | i_action, i_load_used, i_load_first,
//            |                            | i_load_last, i_block_count
//   result   | o_out_valid / i_out_ready  | o_ok, o_error_code, o_granted_first,
//            |                            | o_granted_last, o_released_total, o_segments_now
//
// A load appends one entry at the tail. Allocate and release make one scan pass and
// one merge pass through the chain, one entry per cycle except while a split tail is
// appended in SPLIT; on failure the merge pass is skipped and the result goes to DONE.
// One request is in work at a time; the next is taken while a result waits, and
// its own result holds in DONE until the waiting beat is taken.
// Synchronous active-low reset empties the table; no clearing pass is needed.
module first_fit_segment_allocator (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [1:0]                       i_action,
    input  logic                             i_load_used,
    input  logic [ffsa_pkg::BLOCK_WIDTH-1:0] i_load_first,
    input  logic [ffsa_pkg::BLOCK_WIDTH-1:0] i_load_last,
    input  logic [ffsa_pkg::NEED_W-1:0]      i_block_count,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic                             o_ok,
    output logic [1:0]                       o_error_code,
    output logic [ffsa_pkg::BLOCK_WIDTH-1:0] o_granted_first,
    output logic [ffsa_pkg::BLOCK_WIDTH-1:0] o_granted_last,
    output logic [ffsa_pkg::NEED_W-1:0]      o_released_total,
    output logic [ffsa_pkg::CNT_W-1:0]       o_segments_now
);
    import ffsa_pkg::*;

    t_chain_cmd       w_cmd;
    t_seg             w_head;
    logic [CNT_W-1:0] w_count;

    ffsa_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_action         (i_action),
        .i_load_used      (i_load_used),
        .i_load_first     (i_load_first),
        .i_load_last      (i_load_last),
        .i_block_count    (i_block_count),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_ok             (o_ok),
        .o_error_code     (o_error_code),
        .o_granted_first  (o_granted_first),
        .o_granted_last   (o_granted_last),
        .o_released_total (o_released_total),
        .o_segments_now   (o_segments_now),
        .o_cmd            (w_cmd),
        .i_head           (w_head),
        .i_count          (w_count)
    );

    ffsa_chain u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_head  (w_head),
        .o_count (w_count)
    );

endmodule

// ===== hw/rtl/ffsa_checker.sv =====
// Port-level checks for the first-fit segment allocator, bound to the top level.
module ffsa_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_out_valid,
    input logic                             i_out_ready,
    input logic                             o_ok,
    input logic [1:0]                       o_error_code,
    input logic [ffsa_pkg::BLOCK_WIDTH-1:0] o_granted_first,
    input logic [ffsa_pkg::BLOCK_WIDTH-1:0] o_granted_last,
    input logic [ffsa_pkg::NEED_W-1:0]      o_released_total,
    input logic [ffsa_pkg::CNT_W-1:0]       o_segments_now
);
    import ffsa_pkg::*;

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_segments_now)))
        else $error("result beat dropped or changed while stalled");

    // Table never exceeds its capacity
    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_segments_now <= CNT_MAX))
        else $error("segment count above capacity");

    // A failed request grants and releases nothing
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_ok) |->
        (o_granted_first == '0 && o_granted_last == '0 && o_released_total == '0 &&
         o_error_code != ERR_NONE))
        else $error("failed request reports a grant or release");

    // Nothing is offered right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind first_fit_segment_allocator ffsa_checker u_ffsa_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_ok             (o_ok),
    .o_error_code     (o_error_code),
    .o_granted_first  (o_granted_first),
    .o_granted_last   (o_granted_last),
    .o_released_total (o_released_total),
    .o_segments_now   (o_segments_now)
);

// ===== verif/first_fit_segment_allocator_tb.sv =====
// Self-checking testbench for the first-fit segment allocator.
module first_fit_segment_allocator_tb;
    import ffsa_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]             action;
        logic                   used;
        logic [BLOCK_WIDTH-1:0] first;
        logic [BLOCK_WIDTH-1:0] last;
        logic [NEED_W-1:0]      count;
    } t_request;

    typedef struct {
        logic                   ok;
        logic [1:0]             err;
        logic [BLOCK_WIDTH-1:0] gfirst;
        logic [BLOCK_WIDTH-1:0] glast;
        logic [NEED_W-1:0]      released;
        logic [CNT_W-1:0]       nsegs;
    } t_outcome;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_ready;
    logic [1:0]             i_action = ACT_LOAD;
    logic                   i_load_used = 1'b0;
    logic [BLOCK_WIDTH-1:0] i_load_first = '0;
    logic [BLOCK_WIDTH-1:0] i_load_last = '0;
    logic [NEED_W-1:0]      i_block_count = '0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    logic                   o_ok;
    logic [1:0]             o_error_code;
    logic [BLOCK_WIDTH-1:0] o_granted_first;
    logic [BLOCK_WIDTH-1:0] o_granted_last;
    logic [NEED_W-1:0]      o_released_total;
    logic [CNT_W-1:0]       o_segments_now;

    first_fit_segment_allocator u_top (.*);

    t_request pending_reqs[$];
    t_outcome awaited_outcomes[$];
    t_request cur_req;
    t_seg     seg_tab[MAX_SEGMENTS];
    int       seg_total = 0;
    int       fail_count = 0;
    int       in_gap = 0;
    int       out_gap = 0;
    bit       beat_taken = 1'b0;
    bit       quiet = 1'b0;

    // Clock and reset
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;
    end

    function automatic longint seg_len(int i);
        if (seg_tab[i].last < seg_tab[i].first) return 0;
        return longint'(seg_tab[i].last) - longint'(seg_tab[i].first) + 1;
    endfunction

    // Shift entries above i up one place to make room for a split tail
    function automatic void open_gap(int i);
        for (int j = seg_total; j > i + 1; j--) seg_tab[j] = seg_tab[j-1];
        seg_total++;
    endfunction

    // Fold contiguous neighbours that carry the same mark
    function automatic void merge_neighbours();
        int w;
        w = 0;
        if (seg_total == 0) return;
        for (int r = 1; r < seg_total; r++) begin
            if (seg_tab[w].used == seg_tab[r].used &&
                int'(seg_tab[w].last) + 1 == int'(seg_tab[r].first)) begin
                seg_tab[w].last = seg_tab[r].last;
            end else begin
                w++;
                seg_tab[w] = seg_tab[r];
            end
        end
        seg_total = w + 1;
    endfunction

    function automatic t_outcome allocator_step(t_request rq);
        t_outcome o;
        longint   need, sz, left;
        bit       full_hit;
        o = '{ok: 0, err: ERR_NOFIT, gfirst: 0, glast: 0, released: 0, nsegs: 0};
        need = longint'(rq.count);
        full_hit = 0;
        case (rq.action)
            ACT_LOAD: begin
                if (seg_total >= MAX_SEGMENTS) begin
                    o.err = ERR_FULL;
                end else begin
                    seg_tab[seg_total] = '{used: rq.used, first: rq.first, last: rq.last};
                    seg_total++;
                    o.ok = 1;
                    o.err = ERR_NONE;
                end
            end
            ACT_ALLOC: begin
                if (need != 0) begin
                    for (int i = 0; i < seg_total; i++) begin
                        if (seg_tab[i].used) continue;
                        sz = seg_len(i);
                        if (sz == need) begin
                            seg_tab[i].used = 1;
                            o.ok = 1;
                        end else if (sz > need) begin
                            if (seg_total >= MAX_SEGMENTS) begin
                                o.err = ERR_FULL;
                                break;
                            end
                            open_gap(i);
                            seg_tab[i+1].used = 0;
                            seg_tab[i+1].last = seg_tab[i].last;
                            seg_tab[i].used = 1;
                            seg_tab[i].last = BLOCK_WIDTH'(longint'(seg_tab[i].first) + need - 1);
                            seg_tab[i+1].first = seg_tab[i].last + 1'b1;
                            o.ok = 1;
                        end
                        if (o.ok) begin
                            o.gfirst = seg_tab[i].first;
                            o.glast = seg_tab[i].last;
                            o.err = ERR_NONE;
                            merge_neighbours();
                            break;
                        end
                    end
                end
            end
            ACT_RELEASE: begin
                left = need;
                for (int i = 0; i < seg_total && left > 0; i++) begin
                    if (!seg_tab[i].used) continue;
                    sz = seg_len(i);
                    if (sz <= left) begin
                        seg_tab[i].used = 0;
                        left -= sz;
                    end else begin
                        if (seg_total >= MAX_SEGMENTS) begin
                            full_hit = 1;
                            break;
                        end
                        open_gap(i);
                        seg_tab[i+1].used = 1;
                        seg_tab[i+1].last = seg_tab[i].last;
                        seg_tab[i].used = 0;
                        seg_tab[i].last = BLOCK_WIDTH'(longint'(seg_tab[i].first) + left - 1);
                        seg_tab[i+1].first = seg_tab[i].last + 1'b1;
                        left = 0;
                        break;
                    end
                end
                o.released = NEED_W'(need - left);
                if (need - left > 0) begin
                    o.ok = 1;
                    merge_neighbours();
                end
                if (full_hit) o.err = ERR_FULL;
                else if (need - left > 0) o.err = ERR_NONE;
                else o.err = ERR_NOFIT;
            end
            default: ;
        endcase
        o.nsegs = CNT_W'(seg_total);
        return o;
    endfunction

    function automatic void push_req(logic [1:0] act, int u, int f, int l, int n);
        t_request r;
        r.action = act;
        r.used = u[0];
        r.first = BLOCK_WIDTH'(f);
        r.last = BLOCK_WIDTH'(l);
        r.count = NEED_W'(n);
        pending_reqs.push_back(r);
    endfunction

    // Driver: advance to the next request at the falling edge
    always @(negedge i_clk) begin
        quiet = pending_reqs.size() < 60;
        if (i_rst_n && (!i_in_valid || beat_taken)) begin
            beat_taken = 1'b0;
            if (in_gap > 0) begin
                in_gap--;
                i_in_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                cur_req = pending_reqs.pop_front();
                i_action <= cur_req.action;
                i_load_used <= cur_req.used;
                i_load_first <= cur_req.first;
                i_load_last <= cur_req.last;
                i_block_count <= cur_req.count;
                i_in_valid <= 1'b1;
                if (!quiet && $urandom_range(0, 3) == 0) in_gap = $urandom_range(1, 5);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        // Stall the result side in bursts
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (out_gap > 0) begin
            out_gap--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            if (!quiet && $urandom_range(0, 3) == 0) out_gap = $urandom_range(1, 5);
        end
    end

    // Monitor: predict on each request beat, check each result beat
    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            awaited_outcomes.push_back(allocator_step(cur_req));
            beat_taken = 1'b1;
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (awaited_outcomes.size() == 0) begin
                $display("%0t: unexpected result beat", $time);
                fail_count++;
            end else begin
                want = awaited_outcomes.pop_front();
                if (o_ok !== want.ok) begin
                    $display("%0t: ok exp %0h got %0h", $time, want.ok, o_ok);
                    fail_count++;
                end
                if (o_error_code !== want.err) begin
                    $display("%0t: error_code exp %0h got %0h", $time, want.err, o_error_code);
                    fail_count++;
                end
                if (o_granted_first !== want.gfirst) begin
                    $display("%0t: granted_first exp %0h got %0h", $time, want.gfirst,
                             o_granted_first);
                    fail_count++;
                end
                if (o_granted_last !== want.glast) begin
                    $display("%0t: granted_last exp %0h got %0h", $time, want.glast,
                             o_granted_last);
                    fail_count++;
                end
                if (o_released_total !== want.released) begin
                    $display("%0t: released_total exp %0h got %0h", $time, want.released,
                             o_released_total);
                    fail_count++;
                end
                if (o_segments_now !== want.nsegs) begin
                    $display("%0t: segments_now exp %0h got %0h", $time, want.nsegs,
                             o_segments_now);
                    fail_count++;
                end
            end
        end
    end

    // Timeout guard
    initial begin
        #50_000_000;
        $display("FAIL first_fit_segment_allocator");
        $finish;
    end

    // Stimulus and end of run
    initial begin
        int cursor, len, pick, n;
        cursor = 0;
        // Empty table, zero counts, unknown action
        push_req(ACT_RELEASE, 0, 0, 0, 5);
        push_req(ACT_ALLOC, 0, 0, 0, 1);
        push_req(ACT_ALLOC, 0, 0, 0, 0);
        push_req(ACT_UNUSED, 1, 16'hffff, 16'hffff, 17'h1ffff);
        // Whole block range as one free segment: exact fit and full release
        push_req(ACT_LOAD, 0, 0, 16'hffff, 0);
        push_req(ACT_ALLOC, 0, 0, 0, 65536);
        push_req(ACT_RELEASE, 0, 0, 0, 65536);
        push_req(ACT_RELEASE, 0, 0, 0, 0);
        // Reversed used segment, freed for nothing
        push_req(ACT_LOAD, 1, 10, 3, 0);
        push_req(ACT_RELEASE, 0, 0, 0, 1);
        // Split on allocate and on release
        push_req(ACT_ALLOC, 0, 0, 0, 100);
        push_req(ACT_ALLOC, 0, 0, 0, 65535);
        push_req(ACT_RELEASE, 0, 0, 0, 30);
        push_req(ACT_LOAD, 1, 16'hffff, 0, 0);
        push_req(ACT_ALLOC, 0, 0, 0, 65536);
        push_req(ACT_RELEASE, 0, 0, 0, 65536);

        // Random mix, mostly contiguous loads so merges and fits happen
        for (int k = 0; k < 274; k++) begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 9) == 0) n = $urandom_range(0, 65536);
            else n = $urandom_range(0, 24);
            if (pick < 28) begin
                if ($urandom_range(0, 9) < 7) begin
                    len = $urandom_range(1, 24);
                    push_req(ACT_LOAD, $urandom_range(0, 1), cursor, cursor + len - 1, n);
                    cursor = (cursor + len + ($urandom_range(0, 3) == 0)) & 16'hffff;
                end else begin
                    push_req(ACT_LOAD, $urandom_range(0, 1), $urandom_range(0, 65535),
                             $urandom_range(0, 65535), n);
                end
            end else if (pick < 63) begin
                push_req(ACT_ALLOC, $urandom_range(0, 1), $urandom_range(0, 65535),
                         $urandom_range(0, 65535), n);
            end else if (pick < 96) begin
                push_req(ACT_RELEASE, $urandom_range(0, 1), $urandom_range(0, 65535),
                         $urandom_range(0, 65535), n);
            end else begin
                push_req(ACT_UNUSED, $urandom_range(0, 1), $urandom_range(0, 65535),
                         $urandom_range(0, 65535), n);
            end
        end

        wait (pending_reqs.size() == 0 && !i_in_valid && awaited_outcomes.size() == 0);
        repeat (2200) @(posedge i_clk);
        if (awaited_outcomes.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, awaited_outcomes.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("PASS first_fit_segment_allocator");
        end else begin
            $display("FAIL first_fit_segment_allocator");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/ffsa_pkg.sv
hw/rtl/ffsa_cell.sv
hw/rtl/ffsa_chain.sv
hw/rtl/ffsa_ctrl.sv
hw/rtl/first_fit_segment_allocator.sv
hw/rtl/ffsa_checker.sv
verif/first_fit_segment_allocator_tb.sv
